/* hw/rtl/tkm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkm_pkg: shared types and constants of the ticket k-mutex block
// Command and result records, event kinds, register indexes and defaults.
// ----------------------------------------------------------------------------
package tkm_pkg;

  localparam int unsigned NumResourcesDef = 4;
  localparam int unsigned MaxNodesDef     = 64;
  localparam int unsigned NumTicketRegs   = 4;

  localparam int unsigned NodeIdW  = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned ResW     = 2;
  localparam int unsigned StampW   = 31;
  localparam int unsigned AckCntW  = 6;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [StampW-1:0] StampIdle = {StampW{1'b1}};

  typedef enum logic [1:0] {
    KindRemoteReq = 2'd0,
    KindRemoteAck = 2'd1,
    KindLocalReq  = 2'd2,
    KindRelease   = 2'd3
  } tkm_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNodeId    = 3'd0,
    CfgNodeCount = 3'd1,
    CfgTicket0   = 3'd2,
    CfgTicket1   = 3'd3,
    CfgTicket2   = 3'd4,
    CfgTicket3   = 3'd5
  } tkm_cfg_e;

  typedef enum logic {
    StIdle = 1'b0,
    StWalk = 1'b1
  } tkm_state_e;

  typedef struct packed {
    logic [NodeIdW-1:0]                   node_id;
    logic [CountW-1:0]                    node_count;
    logic [NumTicketRegs-1:0][CountW-1:0] tickets;
  } tkm_cfg_t;

  typedef struct packed {
    tkm_kind_e          kind;
    logic [ResW-1:0]    res;
    logic [NodeIdW-1:0] peer;
    logic [StampW-1:0]  stamp;
    logic               no_acks;
    logic [CountW-1:0]  needed;
  } tkm_cmd_t;

  typedef struct packed {
    logic               send_ack;
    logic [NodeIdW-1:0] ack_dest;
    logic [ResW-1:0]    ack_resource;
    logic               granted;
    logic               last;
  } tkm_result_t;

endpackage

/* hw/rtl/tkm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkm_fifo: small register queue
// Decouples the front from the back and the back from the result side.
// ----------------------------------------------------------------------------
module tkm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/tkm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkm_front: event intake
// Takes input beats, drops absent resources and works out the ack threshold.
// ----------------------------------------------------------------------------
module tkm_front #(
  parameter int unsigned NumResources = tkm_pkg::NumResourcesDef
) (
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   kind_i,
  input  logic [tkm_pkg::ResW-1:0]     resource_i,
  input  logic [tkm_pkg::NodeIdW-1:0]  peer_id_i,
  input  logic [tkm_pkg::StampW-1:0]   stamp_i,
  input  tkm_pkg::tkm_cfg_t            cfg_i,
  output logic                         cmd_push_o,
  output tkm_pkg::tkm_cmd_t            cmd_o,
  input  logic                         cmd_full_i
);

  logic                         present;
  logic [tkm_pkg::CountW-1:0]   tickets;

  assign full    = cmd_full_i;
  assign present = (int'(resource_i) < NumResources);
  assign tickets = cfg_i.tickets[resource_i];

  // drop events for resources that do not exist
  assign cmd_push_o = push && !cmd_full_i && present;

  always_comb begin
    cmd_o.kind    = tkm_pkg::tkm_kind_e'(kind_i);
    cmd_o.res     = resource_i;
    cmd_o.peer    = peer_id_i;
    cmd_o.stamp   = stamp_i;
    cmd_o.no_acks = (tickets >= cfg_i.node_count);
    cmd_o.needed  = cfg_i.node_count - tickets;
  end

endmodule

/* hw/rtl/tkm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkm_back: per-resource exclusion state and result generation
// Idle with result room: one command a cycle; a release walks deferred peers.
// ----------------------------------------------------------------------------
module tkm_back #(
  parameter int unsigned NumResources = tkm_pkg::NumResourcesDef,
  parameter int unsigned MaxNodes     = tkm_pkg::MaxNodesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tkm_pkg::tkm_cfg_t    cfg_i,
  input  tkm_pkg::tkm_cmd_t    cmd_i,
  input  logic                 cmd_empty_i,
  output logic                 cmd_pop_o,
  output logic                 res_push_o,
  output tkm_pkg::tkm_result_t res_o,
  input  logic                 res_full_i
);

  localparam int unsigned NumEntries =
    (NumResources < tkm_pkg::NumTicketRegs) ? NumResources : tkm_pkg::NumTicketRegs;
  localparam int unsigned IdxW = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int unsigned PW   = $clog2(MaxNodes);
  localparam logic [MaxNodes-1:0] BitZero = MaxNodes'(1);
  localparam logic [tkm_pkg::CountW-1:0] MaxNodesC = tkm_pkg::CountW'(MaxNodes);

  logic                          want_q  [NumEntries];
  logic                          held_q  [NumEntries];
  logic [tkm_pkg::StampW-1:0]    stamp_q [NumEntries];
  logic [tkm_pkg::AckCntW-1:0]   cnt_q   [NumEntries];
  logic [MaxNodes-1:0]           map_q   [NumEntries];

  tkm_pkg::tkm_state_e           state_q, state_d;
  logic [MaxNodes-1:0]           walk_q, walk_d;
  logic [PW-1:0]                 peer_q, peer_d;
  logic [tkm_pkg::ResW-1:0]      wres_q, wres_d;

  logic [IdxW-1:0]               idx;
  logic                          upd;
  logic                          want_n, held_n;
  logic [tkm_pkg::StampW-1:0]    stamp_n;
  logic [tkm_pkg::AckCntW-1:0]   cnt_n;
  logic [MaxNodes-1:0]           map_n;

  logic                          mine_later, defer, peer_ok;
  logic [tkm_pkg::CountW-1:0]    cnt_inc;
  logic [MaxNodes-1:0]           peer_bit, self_bit, rel_map;
  logic                          walk_rest_zero;

  assign idx     = cmd_i.res[IdxW-1:0];
  assign peer_ok = ({1'b0, cmd_i.peer} < MaxNodesC);
  assign peer_bit = BitZero << cmd_i.peer[PW-1:0];
  assign self_bit = ({1'b0, cfg_i.node_id} < MaxNodesC) ?
                    (BitZero << cfg_i.node_id[PW-1:0]) : '0;
  assign rel_map  = map_q[idx] & ~self_bit;
  assign cnt_inc  = {1'b0, cnt_q[idx]} + tkm_pkg::CountW'(1);
  assign walk_rest_zero = (walk_q[MaxNodes-1:1] == '0);

  // stamp tie goes to the lower node id
  assign mine_later = (stamp_q[idx] > cmd_i.stamp) ||
                      ((stamp_q[idx] == cmd_i.stamp) && (cfg_i.node_id > cmd_i.peer));
  assign defer      = want_q[idx] && (held_q[idx] || !mine_later);

  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    peer_d     = peer_q;
    wres_d     = wres_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    upd        = 1'b0;
    want_n     = want_q[idx];
    held_n     = held_q[idx];
    stamp_n    = stamp_q[idx];
    cnt_n      = cnt_q[idx];
    map_n      = map_q[idx];
    unique case (state_q)
      tkm_pkg::StIdle: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          upd       = 1'b1;
          unique case (cmd_i.kind)
            tkm_pkg::KindRemoteReq: begin
              if (defer && peer_ok) begin
                map_n = map_q[idx] | peer_bit;
              end else begin
                res_push_o         = 1'b1;
                res_o.send_ack     = 1'b1;
                res_o.ack_dest     = cmd_i.peer;
                res_o.ack_resource = cmd_i.res;
                res_o.last         = 1'b1;
              end
            end
            tkm_pkg::KindRemoteAck: begin
              if (want_q[idx] && !held_q[idx]) begin
                if (cmd_i.no_acks || (cnt_inc >= cmd_i.needed)) begin
                  held_n             = 1'b1;
                  stamp_n            = tkm_pkg::StampIdle;
                  cnt_n              = '0;
                  res_push_o         = 1'b1;
                  res_o.ack_resource = cmd_i.res;
                  res_o.granted      = 1'b1;
                  res_o.last         = 1'b1;
                end else begin
                  cnt_n = cnt_inc[tkm_pkg::AckCntW-1:0];
                end
              end
            end
            tkm_pkg::KindLocalReq: begin
              if (!want_q[idx]) begin
                want_n  = 1'b1;
                held_n  = 1'b0;
                stamp_n = cmd_i.stamp;
                cnt_n   = '0;
                if (cmd_i.no_acks) begin
                  held_n             = 1'b1;
                  stamp_n            = tkm_pkg::StampIdle;
                  res_push_o         = 1'b1;
                  res_o.ack_resource = cmd_i.res;
                  res_o.granted      = 1'b1;
                  res_o.last         = 1'b1;
                end
              end
            end
            tkm_pkg::KindRelease: begin
              want_n  = 1'b0;
              held_n  = 1'b0;
              stamp_n = tkm_pkg::StampIdle;
              map_n   = '0;
              walk_d  = rel_map;
              peer_d  = '0;
              wres_d  = cmd_i.res;
              if (rel_map != '0) begin
                state_d = tkm_pkg::StWalk;
              end
            end
            default: ;
          endcase
        end
      end
      tkm_pkg::StWalk: begin
        // advance one peer a beat; hold while the result queue is full
        if (!res_full_i) begin
          if (walk_q[0]) begin
            res_push_o         = 1'b1;
            res_o.send_ack     = 1'b1;
            res_o.ack_dest     = tkm_pkg::NodeIdW'(peer_q);
            res_o.ack_resource = wres_q;
            res_o.last         = walk_rest_zero;
          end
          walk_d = walk_q >> 1;
          peer_d = peer_q + PW'(1);
          if (walk_rest_zero) begin
            state_d = tkm_pkg::StIdle;
          end
        end
      end
      default: state_d = tkm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkm_pkg::StIdle;
      walk_q  <= '0;
      peer_q  <= '0;
      wres_q  <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      peer_q  <= peer_d;
      wres_q  <= wres_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEntries; i++) begin
        want_q[i]  <= 1'b0;
        held_q[i]  <= 1'b0;
        stamp_q[i] <= tkm_pkg::StampIdle;
        cnt_q[i]   <= '0;
        map_q[i]   <= '0;
      end
    end else if (upd) begin
      want_q[idx]  <= want_n;
      held_q[idx]  <= held_n;
      stamp_q[idx] <= stamp_n;
      cnt_q[idx]   <= cnt_n;
      map_q[idx]   <= map_n;
    end
  end

endmodule

/* hw/rtl/ticket_k_mutex_multi_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_k_mutex_multi_unit: node-side k-mutual exclusion over several resources
// Front intake, command queue, state back end and result queue.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is registered in the command queue, and its
// result is registered in the result queue. Throughput: while the back end is
// idle and the result queue has room, one request, ack or local request per
// cycle. A release walks the deferred map bit-serially up to its highest
// deferred peer, one map position per cycle while the result queue has room.
// Reset: asynchronous; all resources idle, registers at defaults, queues empty.
// ----------------------------------------------------------------------------
module ticket_k_mutex_multi_unit #(
  parameter int unsigned NumResources = tkm_pkg::NumResourcesDef,
  parameter int unsigned MaxNodes     = tkm_pkg::MaxNodesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tkm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tkm_pkg::CountW-1:0]   cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   kind_i,
  input  logic [tkm_pkg::ResW-1:0]     resource_i,
  input  logic [tkm_pkg::NodeIdW-1:0]  peer_id_i,
  input  logic [tkm_pkg::StampW-1:0]   stamp_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         send_ack_o,
  output logic [tkm_pkg::NodeIdW-1:0]  ack_dest_o,
  output logic [tkm_pkg::ResW-1:0]     ack_resource_o,
  output logic                         granted_o,
  output logic                         last_o
);

  localparam int unsigned CmdW = $bits(tkm_pkg::tkm_cmd_t);
  localparam int unsigned ResultW = $bits(tkm_pkg::tkm_result_t);

  logic [tkm_pkg::NodeIdW-1:0]                    node_id_q;
  logic [tkm_pkg::CountW-1:0]                     node_count_q;
  logic [tkm_pkg::NumTicketRegs-1:0][tkm_pkg::CountW-1:0] tickets_q;
  tkm_pkg::tkm_cfg_t                              cfg;

  logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
  tkm_pkg::tkm_cmd_t     cmd_in, cmd_out;
  logic [CmdW-1:0]       cmd_raw;
  logic                  res_push, res_full;
  tkm_pkg::tkm_result_t  res_in, res_out;
  logic [ResultW-1:0]    res_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      node_count_q <= tkm_pkg::CountW'(2);
      for (int i = 0; i < tkm_pkg::NumTicketRegs; i++) begin
        tickets_q[i] <= tkm_pkg::CountW'(1);
      end
    end else if (cfg_we_i) begin
      unique case (tkm_pkg::tkm_cfg_e'(cfg_idx_i))
        tkm_pkg::CfgNodeId:    node_id_q    <= cfg_data_i[tkm_pkg::NodeIdW-1:0];
        tkm_pkg::CfgNodeCount: node_count_q <= cfg_data_i;
        tkm_pkg::CfgTicket0:   tickets_q[0] <= cfg_data_i;
        tkm_pkg::CfgTicket1:   tickets_q[1] <= cfg_data_i;
        tkm_pkg::CfgTicket2:   tickets_q[2] <= cfg_data_i;
        tkm_pkg::CfgTicket3:   tickets_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.node_id    = node_id_q;
    cfg.node_count = node_count_q;
    cfg.tickets    = tickets_q;
  end

  tkm_front #(
    .NumResources (NumResources)
  ) u_front (
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .resource_i (resource_i),
    .peer_id_i  (peer_id_i),
    .stamp_i    (stamp_i),
    .cfg_i      (cfg),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  tkm_fifo #(
    .Width (CmdW),
    .Depth (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty)
  );

  assign cmd_out = tkm_pkg::tkm_cmd_t'(cmd_raw);

  tkm_back #(
    .NumResources (NumResources),
    .MaxNodes     (MaxNodes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  tkm_fifo #(
    .Width (ResultW),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out        = tkm_pkg::tkm_result_t'(res_raw);
  assign send_ack_o     = res_out.send_ack;
  assign ack_dest_o     = res_out.ack_dest;
  assign ack_resource_o = res_out.ack_resource;
  assign granted_o      = res_out.granted;
  assign last_o         = res_out.last;

  // back end never pushes into a full result queue
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result pushed into full queue");

  // a grant is never also an ack, and carries no destination
  a_grant_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && granted_o) |-> (!send_ack_o && (ack_dest_o == '0) && last_o))
    else $error("malformed grant result");

  // the back end takes a command only when one waits and its result has room
  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (!cmd_empty && !res_full))
    else $error("command popped without room");

endmodule

/* verif/ticket_k_mutex_multi_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_k_mutex_multi_unit_test: self-checking bench for the ticket k-mutex
// Drives remote requests, acks, local requests and releases through the
// input queue. It predicts every ack and grant from its own copy of the
// per-resource state, and compares each popped result beat field by field.
// ----------------------------------------------------------------------------
module ticket_k_mutex_multi_unit_test;
  import tkm_pkg::*;

  localparam int unsigned        WalkCycles = 80;
  localparam int unsigned        IdleLimit  = 2000;
  localparam logic [StampW-1:0]  StampMax   = 31'h7FFF_FFFE;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CountW-1:0]   cfg_data_i = '0;
  logic                push       = 1'b0;
  logic                full;
  logic [1:0]          kind_i     = '0;
  logic [ResW-1:0]     resource_i = '0;
  logic [NodeIdW-1:0]  peer_id_i  = '0;
  logic [StampW-1:0]   stamp_i    = '0;
  logic                empty;
  logic                pop        = 1'b0;
  logic                send_ack_o;
  logic [NodeIdW-1:0]  ack_dest_o;
  logic [ResW-1:0]     ack_resource_o;
  logic                granted_o;
  logic                last_o;

  ticket_k_mutex_multi_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push,
    .full,
    .kind_i,
    .resource_i,
    .peer_id_i,
    .stamp_i,
    .empty,
    .pop,
    .send_ack_o,
    .ack_dest_o,
    .ack_resource_o,
    .granted_o,
    .last_o
  );

  // Node registers as last written
  logic [NodeIdW-1:0]  cur_node_id;
  logic [CountW-1:0]   cur_node_count;
  logic [CountW-1:0]   cur_tickets[NumTicketRegs];

  // Per-resource mutex state
  logic                wanting[NumResourcesDef];
  logic                holding[NumResourcesDef];
  logic [StampW-1:0]   req_stamp[NumResourcesDef];
  logic [AckCntW-1:0]  acks_seen[NumResourcesDef];
  logic [63:0]         deferred[NumResourcesDef];

  tkm_result_t         owed[$];
  int                  mismatches = 0;
  int                  burst_left = 0;
  bit                  steady     = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void owe(logic ack, logic [NodeIdW-1:0] dest, logic [ResW-1:0] res,
                              logic grant);
    tkm_result_t m;
    m.send_ack     = ack;
    m.ack_dest     = dest;
    m.ack_resource = res;
    m.granted      = grant;
    m.last         = 1'b0;
    owed.insert(owed.size(), m);
  endfunction

  // Advance the node state by one event and queue the acks and grants it owes
  function automatic void apply_event(tkm_kind_e kind, logic [ResW-1:0] res,
                                      logic [NodeIdW-1:0] peer, logic [StampW-1:0] stamp);
    logic              no_acks;
    logic [CountW-1:0] needed;
    logic [CountW-1:0] cnt;
    logic              defer;
    logic [63:0]       map;
    int                depth;
    tkm_result_t       tail;
    no_acks = cur_tickets[res] >= cur_node_count;
    needed  = no_acks ? '0 : cur_node_count - cur_tickets[res];
    depth   = owed.size();
    case (kind)
      KindRemoteReq: begin
        defer = wanting[res] && (holding[res] || !(req_stamp[res] > stamp ||
                (req_stamp[res] == stamp && cur_node_id > peer)));
        if (defer) deferred[res][peer] = 1'b1;
        else owe(1'b1, peer, res, 1'b0);
      end
      KindRemoteAck: begin
        if (wanting[res] && !holding[res]) begin
          cnt = CountW'(acks_seen[res]) + 1'b1;
          if (no_acks || cnt >= needed) begin
            holding[res]   = 1'b1;
            req_stamp[res] = StampIdle;
            acks_seen[res] = '0;
            owe(1'b0, '0, res, 1'b1);
          end else begin
            acks_seen[res] = cnt[AckCntW-1:0];
          end
        end
      end
      KindLocalReq: begin
        if (!wanting[res]) begin
          wanting[res]   = 1'b1;
          holding[res]   = 1'b0;
          req_stamp[res] = stamp;
          acks_seen[res] = '0;
          if (no_acks) begin
            holding[res]   = 1'b1;
            req_stamp[res] = StampIdle;
            owe(1'b0, '0, res, 1'b1);
          end
        end
      end
      default: begin
        // drop our own id, then ack the rest in ascending order
        map = deferred[res] & ~(64'd1 << cur_node_id);
        wanting[res]   = 1'b0;
        holding[res]   = 1'b0;
        req_stamp[res] = StampIdle;
        deferred[res]  = '0;
        for (int p = 0; p < 64; p++) begin
          if (map[p]) owe(1'b1, NodeIdW'(p), res, 1'b0);
        end
      end
    endcase
    if (owed.size() > depth) begin
      tail      = owed[owed.size() - 1];
      tail.last = 1'b1;
      owed[owed.size() - 1] = tail;
    end
  endfunction

  task automatic write_reg(tkm_cfg_e idx, logic [CountW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [NodeIdW-1:0] id, logic [CountW-1:0] nodes,
                             logic [CountW-1:0] t0, logic [CountW-1:0] t1,
                             logic [CountW-1:0] t2, logic [CountW-1:0] t3);
    write_reg(CfgNodeId, CountW'(id));
    write_reg(CfgNodeCount, nodes);
    write_reg(CfgTicket0, t0);
    write_reg(CfgTicket1, t1);
    write_reg(CfgTicket2, t2);
    write_reg(CfgTicket3, t3);
    cfg_we_i       <= 1'b0;
    cur_node_id    = id;
    cur_node_count = nodes;
    cur_tickets[0] = t0;
    cur_tickets[1] = t1;
    cur_tickets[2] = t2;
    cur_tickets[3] = t3;
  endtask

  // Send one event beat; the sender runs in bursts with random gaps between them
  task automatic send_event(tkm_kind_e kind, logic [ResW-1:0] res,
                            logic [NodeIdW-1:0] peer, logic [StampW-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    push       <= 1'b1;
    kind_i     <= kind;
    resource_i <= res;
    peer_id_i  <= peer;
    stamp_i    <= stamp;
    do @(posedge clk_i); while (full !== 1'b0);
    apply_event(kind, res, peer, stamp);
  endtask

  // Hold off until every owed beat has come and any release walk has finished
  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    while (owed.size() != 0) @(posedge clk_i);
    repeat (WalkCycles) @(posedge clk_i);
  endtask

  function automatic logic [StampW-1:0] pick_stamp();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return StampMax;
      2, 3:    return StampW'($urandom_range(0, 15));
      default: return StampW'($urandom_range(0, 32'h7FFF_FFFE));
    endcase
  endfunction

  // Stamp just before, at or just after our own, to hit the tie break
  function automatic logic [StampW-1:0] near_stamp(logic [StampW-1:0] s);
    case ($urandom_range(0, 2))
      0:       return (s == '0) ? s : s - 1'b1;
      1:       return s;
      default: return (s >= StampMax) ? StampMax : s + 1'b1;
    endcase
  endfunction

  task automatic random_event();
    logic [ResW-1:0]    res;
    logic [NodeIdW-1:0] peer;
    int                 roll;
    res  = ResW'($urandom_range(0, 3));
    peer = NodeIdW'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      send_event(tkm_kind_e'($urandom_range(0, 3)), res, peer, pick_stamp());
    end else if (!wanting[res]) begin
      if (roll < 55) send_event(KindLocalReq, res, peer, pick_stamp());
      else send_event(KindRemoteReq, res, peer, pick_stamp());
    end else if (!holding[res]) begin
      if (roll < 70) send_event(KindRemoteAck, res, peer, pick_stamp());
      else if (roll < 92) send_event(KindRemoteReq, res, peer, near_stamp(req_stamp[res]));
      else send_event(KindRelease, res, peer, pick_stamp());
    end else begin
      if (roll < 75) send_event(KindRemoteReq, res, peer, pick_stamp());
      else send_event(KindRelease, res, peer, pick_stamp());
    end
  endtask

  task automatic test_directed();
    steady = 1'b0;
    load_config(6'd5, 7'd4, 7'd1, 7'd2, 7'd4, 7'd64);
    send_event(KindRemoteReq, 2'd0, 6'd63, 31'd0);
    send_event(KindRemoteAck, 2'd0, 6'd1, 31'd0);
    send_event(KindRelease, 2'd3, 6'd0, 31'd0);
    send_event(KindLocalReq, 2'd0, 6'd0, 31'd100);
    send_event(KindLocalReq, 2'd0, 6'd0, 31'd7);
    send_event(KindRemoteReq, 2'd0, 6'd3, 31'd100);
    send_event(KindRemoteReq, 2'd0, 6'd9, 31'd100);
    send_event(KindRemoteReq, 2'd0, 6'd0, StampMax);
    send_event(KindRemoteReq, 2'd0, 6'd5, 31'd0);
    send_event(KindRemoteReq, 2'd0, 6'd2, 31'd101);
    send_event(KindRemoteAck, 2'd0, 6'd1, 31'd0);
    send_event(KindRemoteAck, 2'd0, 6'd2, 31'd0);
    send_event(KindRemoteAck, 2'd0, 6'd3, 31'd0);
    send_event(KindRemoteAck, 2'd0, 6'd4, 31'd0);
    send_event(KindRemoteReq, 2'd0, 6'd63, 31'd0);
    send_event(KindRemoteReq, 2'd0, 6'd5, 31'd0);
    send_event(KindRelease, 2'd0, 6'd0, 31'd0);
    send_event(KindLocalReq, 2'd3, 6'd0, StampMax);
    send_event(KindLocalReq, 2'd2, 6'd0, 31'd0);
    send_event(KindLocalReq, 2'd1, 6'd0, 31'd50);
    send_event(KindRemoteAck, 2'd1, 6'd63, 31'd0);
    send_event(KindRemoteAck, 2'd1, 6'd0, 31'd0);
    send_event(KindRelease, 2'd1, 6'd0, 31'd0);
    send_event(KindRelease, 2'd2, 6'd0, 31'd0);
    send_event(KindRelease, 2'd3, 6'd0, 31'd0);
    settle();
  endtask

  // Every peer deferred on one resource, 63 acks to the grant, then the longest release
  task automatic test_full_deferral();
    int off;
    steady = 1'b1;
    load_config(6'd63, 7'd64, 7'd1, 7'd64, 7'd63, 7'd62);
    off = $urandom_range(0, 63);
    send_event(KindLocalReq, 2'd0, 6'd0, 31'd1000);
    for (int k = 0; k < 64; k++) begin
      send_event(KindRemoteReq, 2'd0, NodeIdW'((k + off) % 64),
                 StampW'($urandom_range(1001, 32'h7FFF_FFFE)));
    end
    steady = 1'b0;
    for (int k = 0; k < 63; k++) begin
      send_event(KindRemoteAck, 2'd0, NodeIdW'($urandom_range(0, 63)), pick_stamp());
    end
    send_event(KindLocalReq, 2'd1, 6'd0, pick_stamp());
    send_event(KindLocalReq, 2'd3, 6'd0, pick_stamp());
    send_event(KindRemoteAck, 2'd3, 6'd7, pick_stamp());
    send_event(KindRemoteAck, 2'd3, 6'd8, pick_stamp());
    send_event(KindRelease, 2'd0, 6'd0, pick_stamp());
    send_event(KindRelease, 2'd1, 6'd0, pick_stamp());
    send_event(KindRelease, 2'd3, 6'd0, pick_stamp());
    settle();
  endtask

  task automatic test_random_traffic();
    logic [CountW-1:0] nodes;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          nodes = 7'd2;
          load_config(6'd0, nodes, 7'd1, 7'd2, 7'd64, 7'd1);
        end
        1: begin
          nodes = CountW'($urandom_range(2, 6));
          load_config(NodeIdW'($urandom_range(0, 63)), nodes,
                      CountW'($urandom_range(1, nodes)), CountW'($urandom_range(1, nodes)),
                      CountW'($urandom_range(1, nodes)), CountW'($urandom_range(1, 64)));
        end
        2: begin
          nodes = CountW'($urandom_range(7, 16));
          load_config(NodeIdW'($urandom_range(0, 63)), nodes,
                      CountW'($urandom_range(nodes - 3, nodes)),
                      CountW'($urandom_range(1, nodes)),
                      CountW'($urandom_range(nodes - 5, nodes + 1)),
                      CountW'($urandom_range(1, 3)));
        end
        default: begin
          nodes = CountW'($urandom_range(17, 64));
          load_config(6'd63, nodes, CountW'($urandom_range(nodes - 4, nodes)),
                      CountW'($urandom_range(nodes - 2, 64)),
                      CountW'($urandom_range(nodes - 6, nodes)), 7'd1);
        end
      endcase
      steady = (ph == 2);
      for (int i = 0; i < 70; i++) begin
        random_event();
        // let the results run dry once mid-phase
        if (i == 35) settle();
      end
      settle();
    end
  endtask

  // Result side: check each popped beat against the oldest owed one
  initial begin
    int          mode;
    int          mode_left;
    int          stall_left;
    tkm_result_t exp_beat;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (owed.size() == 0) begin
          $error("result beat with nothing owed: dest %0d res %0d granted %0d",
                 ack_dest_o, ack_resource_o, granted_o);
          mismatches++;
        end else begin
          exp_beat = owed[0];
          owed.delete(0);
          if (send_ack_o !== exp_beat.send_ack) begin
            $error("send_ack: expected %0d, got %0d", exp_beat.send_ack, send_ack_o);
            mismatches++;
          end
          if (ack_dest_o !== exp_beat.ack_dest) begin
            $error("ack_dest: expected %0d, got %0d", exp_beat.ack_dest, ack_dest_o);
            mismatches++;
          end
          if (ack_resource_o !== exp_beat.ack_resource) begin
            $error("ack_resource: expected %0d, got %0d", exp_beat.ack_resource,
                   ack_resource_o);
            mismatches++;
          end
          if (granted_o !== exp_beat.granted) begin
            $error("granted: expected %0d, got %0d", exp_beat.granted, granted_o);
            mismatches++;
          end
          if (last_o !== exp_beat.last) begin
            $error("last: expected %0d, got %0d", exp_beat.last, last_o);
            mismatches++;
          end
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  // End the run if nothing moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("ticket_k_mutex_multi_unit_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    cur_node_id    = '0;
    cur_node_count = 7'd2;
    for (int i = 0; i < NumTicketRegs; i++) cur_tickets[i] = 7'd1;
    for (int i = 0; i < NumResourcesDef; i++) begin
      wanting[i]   = 1'b0;
      holding[i]   = 1'b0;
      req_stamp[i] = StampIdle;
      acks_seen[i] = '0;
      deferred[i]  = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_deferral();
    test_random_traffic();
    settle();
    if (mismatches == 0 && owed.size() == 0) begin
      $display("ticket_k_mutex_multi_unit_test: PASS");
    end else begin
      $display("ticket_k_mutex_multi_unit_test: FAIL");
    end
    $finish;
  end

endmodule

/* ticket_k_mutex_multi_unit.f */
hw/rtl/tkm_pkg.sv
hw/rtl/tkm_fifo.sv
hw/rtl/tkm_front.sv
hw/rtl/tkm_back.sv
hw/rtl/ticket_k_mutex_multi_unit.sv
verif/ticket_k_mutex_multi_unit_test.sv
